[design/lre_pkg.sv]
// lre_pkg: shared types, constants and saturating arithmetic for the
// generalized laguerre recurrence evaluator; no dependencies
package lre_pkg;

	localparam int VAL_W = 64;
	localparam int PT_W = 39;
	localparam int IDX_W = 3;
	localparam int CNT_W = 4;
	localparam int ACC_W = 2 * VAL_W;

	localparam int M_MAX_DEF = 8;
	localparam int N_MAX_DEF = 8;
	localparam logic [CNT_W-1:0] M_COUNT_RST = 4'd8;
	localparam logic [CNT_W-1:0] N_COUNT_RST = 4'd8;

	localparam logic signed [VAL_W-1:0] ONE_Q = 64'sh0000_0001_0000_0000;
	localparam logic signed [VAL_W-1:0] TWO_Q = 64'sh0000_0002_0000_0000;
	localparam logic signed [VAL_W-1:0] SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [VAL_W-1:0] SAT_MIN = 64'sh8000_0000_0000_0000;

	typedef struct packed {
		logic [CNT_W-1:0] m_count;
		logic [CNT_W-1:0] n_count;
	} cfg_t;

	typedef struct packed {
		logic                    start;
		logic signed [VAL_W-1:0] a;
		logic signed [VAL_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [VAL_W-1:0] res;
	} mul_rsp_t;

	// round(2^32 / n) in q32.32
	function automatic logic signed [VAL_W-1:0] recip(input logic [IDX_W-1:0] n);
		logic signed [VAL_W-1:0] r;
		case (n)
			3'd1:    r = 64'sd4294967296;
			3'd2:    r = 64'sd2147483648;
			3'd3:    r = 64'sd1431655765;
			3'd4:    r = 64'sd1073741824;
			3'd5:    r = 64'sd858993459;
			3'd6:    r = 64'sd715827883;
			3'd7:    r = 64'sd613566757;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [VAL_W-1:0] sat_add(
		input logic signed [VAL_W-1:0] a,
		input logic signed [VAL_W-1:0] b
	);
		logic signed [VAL_W-1:0] s;
		s = a + b;
		if (a[VAL_W-1] == b[VAL_W-1] && s[VAL_W-1] != a[VAL_W-1])
			s = a[VAL_W-1] ? SAT_MIN : SAT_MAX;
		return s;
	endfunction

	function automatic logic signed [VAL_W-1:0] sat_sub(
		input logic signed [VAL_W-1:0] a,
		input logic signed [VAL_W-1:0] b
	);
		logic signed [VAL_W-1:0] s;
		s = a - b;
		if (a[VAL_W-1] != b[VAL_W-1] && s[VAL_W-1] != a[VAL_W-1])
			s = a[VAL_W-1] ? SAT_MIN : SAT_MAX;
		return s;
	endfunction

endpackage

[design/lre_cfg.sv]
// lre_cfg: apb register file holding m_count and n_count
// depends on lre_pkg
module lre_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [2:0]                paddr,
	input  logic [31:0]               pwdata,
	input  logic                      pready,
	output logic [31:0]               prdata,
	output lre_pkg::cfg_t             cfg
);

	localparam logic REG_M_COUNT = 1'b0;
	localparam logic REG_N_COUNT = 1'b1;

	logic [lre_pkg::CNT_W-1:0] m_count_q;
	logic [lre_pkg::CNT_W-1:0] n_count_q;
	logic                      wr_en;

	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_count_q <= lre_pkg::M_COUNT_RST;
			n_count_q <= lre_pkg::N_COUNT_RST;
		end else if (wr_en) begin
			case (paddr[2])
				REG_M_COUNT: m_count_q <= pwdata[lre_pkg::CNT_W-1:0];
				REG_N_COUNT: n_count_q <= pwdata[lre_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_M_COUNT: prdata = {28'b0, m_count_q};
			REG_N_COUNT: prdata = {28'b0, n_count_q};
			default:     prdata = '0;
		endcase
	end

	assign cfg.m_count = m_count_q;
	assign cfg.n_count = n_count_q;

endmodule

[design/lre_mul.sv]
// lre_mul: q32.32 multiplier, rounded and saturated, built from one shared
// 32x32 multiplier over four partial products; depends on lre_pkg
module lre_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  lre_pkg::mul_req_t req,
	output lre_pkg::mul_rsp_t rsp
);

	logic [lre_pkg::VAL_W-1:0] x_q;
	logic [lre_pkg::VAL_W-1:0] y_q;
	logic                      neg_q;
	logic [2:0]                step_q;
	logic                      run_q;
	logic                      done_q;
	logic [lre_pkg::VAL_W-1:0] prod_s1;
	logic [1:0]                sh_s1;
	logic                      pv_s1;
	logic [lre_pkg::ACC_W-1:0] acc_q;
	logic signed [lre_pkg::VAL_W-1:0] res_q;

	logic [31:0]               x_part;
	logic [31:0]               y_part;
	logic [1:0]                sh_c;
	logic [lre_pkg::VAL_W-1:0] prod_c;
	logic [lre_pkg::VAL_W-1:0] a_mag;
	logic [lre_pkg::VAL_W-1:0] b_mag;
	logic [lre_pkg::VAL_W-1:0] r_mag;
	logic signed [lre_pkg::VAL_W-1:0] fin_c;

	assign a_mag = req.a[lre_pkg::VAL_W-1] ? lre_pkg::VAL_W'(-req.a) : req.a;
	assign b_mag = req.b[lre_pkg::VAL_W-1] ? lre_pkg::VAL_W'(-req.b) : req.b;

	// partial product order: lo*lo, lo*hi, hi*lo, hi*hi
	always_comb begin
		case (step_q)
			3'd0: begin
				x_part = x_q[31:0];
				y_part = y_q[31:0];
				sh_c = 2'd0;
			end
			3'd1: begin
				x_part = x_q[31:0];
				y_part = y_q[63:32];
				sh_c = 2'd1;
			end
			3'd2: begin
				x_part = x_q[63:32];
				y_part = y_q[31:0];
				sh_c = 2'd1;
			end
			3'd3: begin
				x_part = x_q[63:32];
				y_part = y_q[63:32];
				sh_c = 2'd2;
			end
			default: begin
				x_part = '0;
				y_part = '0;
				sh_c = 2'd0;
			end
		endcase
	end

	assign prod_c = {32'b0, x_part} * {32'b0, y_part};

	// accumulator was seeded with half an lsb, so it already holds the rounded sum
	assign r_mag = acc_q[95:32];
	always_comb begin
		if (|acc_q[127:96])
			fin_c = neg_q ? lre_pkg::SAT_MIN : lre_pkg::SAT_MAX;
		else if (neg_q)
			fin_c = (r_mag > 64'h8000_0000_0000_0000) ? lre_pkg::SAT_MIN
			                                          : lre_pkg::VAL_W'(-r_mag);
		else
			fin_c = r_mag[63] ? lre_pkg::SAT_MAX : r_mag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			pv_s1 <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				step_q <= '0;
				pv_s1 <= 1'b0;
			end else if (run_q) begin
				step_q <= step_q + 3'd1;
				pv_s1 <= (step_q < 3'd4);
				if (step_q == 3'd5) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q <= a_mag;
			y_q <= b_mag;
			neg_q <= req.a[lre_pkg::VAL_W-1] ^ req.b[lre_pkg::VAL_W-1];
			acc_q <= lre_pkg::ACC_W'(64'h8000_0000);
		end else begin
			if (pv_s1)
				acc_q <= acc_q + (lre_pkg::ACC_W'(prod_s1) << {sh_s1, 5'b0});
		end
		prod_s1 <= prod_c;
		sh_s1 <= sh_c;
		if (run_q && step_q == 3'd5)
			res_q <= fin_c;
	end

	assign rsp.done = done_q;
	assign rsp.res = res_q;

endmodule

[design/laguerre_recurrence_evaluator.sv]
// laguerre_recurrence_evaluator: top level, sequencer around the shared
// multiplier; depends on lre_pkg, lre_cfg and lre_mul
//
// One point z is taken when start is high and busy is low; the block then
// streams L^m_n(z) for m = 0..m_count-1 (outer) and n = 0..n_count-1 (inner),
// with counts above M_MAX or N_MAX clamped, one value per valid strobe, with
// last on the final value. The receiver cannot stall: each value is on the
// ports for exactly one cycle. Degrees 0 and 1 need no product; every higher
// degree waits on the single 32x32 multiplier, which forms four q32.32
// products per value, each from four partial products. busy stays high
// until the last value is out; a point with a zero count yields nothing.
module laguerre_recurrence_evaluator #(
	parameter int M_MAX = lre_pkg::M_MAX_DEF,
	parameter int N_MAX = lre_pkg::N_MAX_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [2:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [lre_pkg::PT_W-1:0]   point,
	output logic                              valid,
	output logic [lre_pkg::IDX_W-1:0]         order_m,
	output logic [lre_pkg::IDX_W-1:0]         order_n,
	output logic signed [lre_pkg::VAL_W-1:0]  value,
	output logic                              last
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EVAL = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;

	localparam logic [1:0] OP_T1 = 2'd0;
	localparam logic [1:0] OP_T2 = 2'd1;
	localparam logic [1:0] OP_P1 = 2'd2;
	localparam logic [1:0] OP_P2 = 2'd3;

	lre_pkg::cfg_t     cfg;
	lre_pkg::mul_req_t mul_req;
	lre_pkg::mul_rsp_t mul_rsp;

	logic [1:0]                        state_q;
	logic [1:0]                        op_q;
	logic                              issued_q;
	logic [lre_pkg::IDX_W-1:0]         m_q;
	logic [lre_pkg::IDX_W-1:0]         n_q;
	logic [lre_pkg::CNT_W-1:0]         mc_q;
	logic [lre_pkg::CNT_W-1:0]         nc_q;
	logic signed [lre_pkg::VAL_W-1:0]  z_q;
	logic signed [lre_pkg::VAL_W-1:0]  prev_one_q;
	logic signed [lre_pkg::VAL_W-1:0]  prev_two_q;
	logic signed [lre_pkg::VAL_W-1:0]  d_q;
	logic signed [lre_pkg::VAL_W-1:0]  ta_q;
	logic signed [lre_pkg::VAL_W-1:0]  tb_q;
	logic signed [lre_pkg::VAL_W-1:0]  p1_q;
	logic                              valid_q;
	logic                              last_q;
	logic [lre_pkg::IDX_W-1:0]         order_m_q;
	logic [lre_pkg::IDX_W-1:0]         order_n_q;
	logic signed [lre_pkg::VAL_W-1:0]  value_q;

	logic [lre_pkg::CNT_W-1:0]         mc_c;
	logic [lre_pkg::CNT_W-1:0]         nc_c;
	logic                              accept;
	logic signed [31:0]                mm1_hi;
	logic signed [lre_pkg::VAL_W-1:0]  mm1;
	logic signed [lre_pkg::VAL_W-1:0]  m1_q;
	logic signed [lre_pkg::VAL_W-1:0]  r_n;
	logic                              emit;
	logic signed [lre_pkg::VAL_W-1:0]  emit_v;
	logic                              n_end;
	logic                              m_end;

	lre_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.pready  (pready),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	lre_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	assign pready = 1'b1;
	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign mc_c = (cfg.m_count > lre_pkg::CNT_W'(M_MAX)) ? lre_pkg::CNT_W'(M_MAX) : cfg.m_count;
	assign nc_c = (cfg.n_count > lre_pkg::CNT_W'(N_MAX)) ? lre_pkg::CNT_W'(N_MAX) : cfg.n_count;

	// (m - 1) and (m + 1) as q32.32
	assign mm1_hi = $signed({29'b0, m_q}) - 32'sd1;
	assign mm1 = {mm1_hi, 32'b0};
	assign m1_q = {29'b0, m_q, 32'b0} + lre_pkg::ONE_Q;
	assign r_n = lre_pkg::recip(n_q);

	assign n_end = ({1'b0, n_q} == nc_q - 4'd1);
	assign m_end = ({1'b0, m_q} == mc_q - 4'd1);

	// operand select for the shared multiplier
	always_comb begin
		mul_req.start = (state_q == ST_MUL) && !issued_q;
		case (op_q)
			OP_T1: begin
				mul_req.a = d_q;
				mul_req.b = r_n;
			end
			OP_T2: begin
				mul_req.a = mm1;
				mul_req.b = r_n;
			end
			OP_P1: begin
				mul_req.a = ta_q;
				mul_req.b = prev_one_q;
			end
			OP_P2: begin
				mul_req.a = tb_q;
				mul_req.b = prev_two_q;
			end
			default: begin
				mul_req.a = '0;
				mul_req.b = '0;
			end
		endcase
	end

	always_comb begin
		emit = 1'b0;
		emit_v = lre_pkg::ONE_Q;
		case (state_q)
			ST_EVAL: begin
				if (n_q == 3'd0) begin
					emit = 1'b1;
					emit_v = lre_pkg::ONE_Q;
				end else if (n_q == 3'd1) begin
					emit = 1'b1;
					emit_v = lre_pkg::sat_sub(m1_q, z_q);
				end
			end
			ST_MUL: begin
				if (issued_q && mul_rsp.done && op_q == OP_P2) begin
					emit = 1'b1;
					emit_v = lre_pkg::sat_sub(p1_q, mul_rsp.res);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= OP_T1;
			issued_q <= 1'b0;
			m_q <= '0;
			n_q <= '0;
			mc_q <= '0;
			nc_q <= '0;
			valid_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			valid_q <= emit;
			last_q <= emit && n_end && m_end;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						mc_q <= mc_c;
						nc_q <= nc_c;
						m_q <= '0;
						n_q <= '0;
						if (mc_c != '0 && nc_c != '0)
							state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (!emit) begin
						state_q <= ST_MUL;
						op_q <= OP_T1;
						issued_q <= 1'b0;
					end
				end
				ST_MUL: begin
					if (!issued_q) begin
						issued_q <= 1'b1;
					end else if (mul_rsp.done) begin
						issued_q <= 1'b0;
						op_q <= op_q + 2'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (emit) begin
				if (n_end) begin
					n_q <= '0;
					m_q <= m_q + 3'd1;
				end else begin
					n_q <= n_q + 3'd1;
				end
				state_q <= (n_end && m_end) ? ST_IDLE : ST_EVAL;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			z_q <= '0;
			prev_one_q <= '0;
			prev_two_q <= '0;
		end else begin
			if (accept)
				z_q <= lre_pkg::VAL_W'(point);
			if (emit) begin
				prev_two_q <= prev_one_q;
				prev_one_q <= emit_v;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EVAL)
			d_q <= lre_pkg::sat_sub(mm1, z_q);
		if (state_q == ST_MUL && issued_q && mul_rsp.done) begin
			case (op_q)
				OP_T1:   ta_q <= lre_pkg::sat_add(lre_pkg::TWO_Q, mul_rsp.res);
				OP_T2:   tb_q <= lre_pkg::sat_add(lre_pkg::ONE_Q, mul_rsp.res);
				OP_P1:   p1_q <= mul_rsp.res;
				default: ;
			endcase
		end
		if (emit) begin
			order_m_q <= m_q;
			order_n_q <= n_q;
			value_q <= emit_v;
		end
	end

	assign valid = valid_q;
	assign last = last_q;
	assign order_m = order_m_q;
	assign order_n = order_n_q;
	assign value = value_q;

	// the final value of a point leaves the block idle
	assert property (@(posedge clk) disable iff (!arst_n) valid && last |-> !busy)
		else $error("busy after final value");

	// the multiplier is only started by a running point
	assert property (@(posedge clk) disable iff (!arst_n) mul_req.start |-> busy)
		else $error("multiplier started while idle");

	// a value is strobed only for a point that was in progress
	assert property (@(posedge clk) disable iff (!arst_n) valid |-> $past(busy))
		else $error("value strobed without a point");

	// a multiplier result arrives only while waiting on it
	assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> (state_q == ST_MUL) && issued_q)
		else $error("unexpected multiplier result");

endmodule

[tb/laguerre_recurrence_evaluator_tb.sv]
// laguerre_recurrence_evaluator_tb: self-checking bench for the laguerre evaluator,
// with directed rows, random points and count settings, and a bit-true value predictor
// depends on lre_pkg and laguerre_recurrence_evaluator
module laguerre_recurrence_evaluator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lre_pkg::*;

	localparam int ITEMS = 350;
	localparam longint CYCLE_LIMIT = 3_000_000;
	localparam int SETTLE = 40;

	typedef enum logic [2:0] {
		ADDR_M_COUNT = 3'd0,
		ADDR_N_COUNT = 3'd4
	} reg_addr_e;

	typedef struct packed {
		logic [IDX_W-1:0]        m;
		logic [IDX_W-1:0]        n;
		logic signed [VAL_W-1:0] v;
		logic                    lst;
	} lag_value_t;

	typedef struct packed {
		logic [CNT_W-1:0] m_cnt;
		logic [CNT_W-1:0] n_cnt;
		logic [PT_W-1:0]  z;
		logic             typed;
		logic [VAL_W-1:0] want;
	} point_row_t;

	// 1/n in q32.32, round to nearest
	localparam logic signed [VAL_W-1:0] INV_DEG [8] = '{
		64'sd0, 64'sd4294967296, 64'sd2147483648, 64'sd1431655765,
		64'sd1073741824, 64'sd858993459, 64'sd715827883, 64'sd613566757
	};

	localparam point_row_t DIR_ROWS [20] = '{
		'{4'd8,  4'd8, 39'h00_0000_0000, 1'b0, 64'h0},
		'{4'd8,  4'd8, 39'h3F_FFFF_FFFF, 1'b0, 64'h0},
		'{4'd8,  4'd8, 39'h40_0000_0000, 1'b0, 64'h0},
		'{4'd1,  4'd1, 39'd12345,        1'b1, 64'h1_0000_0000},
		'{4'd1,  4'd1, 39'h7F_FFFF_FFFF, 1'b1, 64'h1_0000_0000},
		'{4'd1,  4'd1, 39'h40_0000_0000, 1'b1, 64'h1_0000_0000},
		'{4'd1,  4'd1, 39'h3F_FFFF_FFFF, 1'b1, 64'h1_0000_0000},
		'{4'd0,  4'd8, 39'h05_0000_0000, 1'b0, 64'h0},
		'{4'd8,  4'd0, 39'h79_0000_0000, 1'b0, 64'h0},
		'{4'd0,  4'd0, 39'h7F_FFFF_FFFF, 1'b0, 64'h0},
		'{4'd1,  4'd2, 39'h01_0000_0000, 1'b0, 64'h0},
		'{4'd15, 4'd1, 39'h03_0000_0000, 1'b0, 64'h0},
		'{4'd1,  4'd15, 39'h7D_0000_0000, 1'b0, 64'h0},
		'{4'd9,  4'd9, 39'h04_0000_0000, 1'b0, 64'h0},
		'{4'd3,  4'd5, 39'h00_8000_0000, 1'b0, 64'h0},
		'{4'd2,  4'd8, 39'h7F_8000_0000, 1'b0, 64'h0},
		'{4'd8,  4'd3, 39'h00_0000_0001, 1'b0, 64'h0},
		'{4'd4,  4'd4, 39'h7F_FFFF_FFFF, 1'b0, 64'h0},
		'{4'd8,  4'd8, 39'h3F_8000_0000, 1'b0, 64'h0},
		'{4'd8,  4'd8, 39'h40_8000_0000, 1'b0, 64'h0}
	};

	logic                    clk;
	logic                    arst_n;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [2:0]              paddr;
	logic [31:0]             pwdata;
	logic [31:0]             prdata;
	logic                    pready;
	logic                    start;
	logic                    busy;
	logic signed [PT_W-1:0]  point;
	logic                    valid;
	logic [IDX_W-1:0]        order_m;
	logic [IDX_W-1:0]        order_n;
	logic signed [VAL_W-1:0] value;
	logic                    last;

	lag_value_t pending_vals[$];
	int errs;
	longint cycle_cnt;

	// predictor copy of the counts and recurrence state
	logic [CNT_W-1:0]        m_cfg;
	logic [CNT_W-1:0]        n_cfg;
	logic signed [VAL_W-1:0] z_held;
	logic signed [VAL_W-1:0] l_prev1;
	logic signed [VAL_W-1:0] l_prev2;

	laguerre_recurrence_evaluator u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.start   (start),
		.busy    (busy),
		.point   (point),
		.valid   (valid),
		.order_m (order_m),
		.order_n (order_n),
		.value   (value),
		.last    (last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic report(input string msg);
		errs++;
		$display("mismatch at %0t ns: %s", $time, msg);
	endtask

	function automatic logic signed [VAL_W-1:0] add_sat(
		input logic signed [VAL_W-1:0] a,
		input logic signed [VAL_W-1:0] b
	);
		logic [VAL_W:0] s;
		s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
		if (s[VAL_W] != s[VAL_W-1])
			return s[VAL_W] ? SAT_MIN : SAT_MAX;
		return s[VAL_W-1:0];
	endfunction

	function automatic logic signed [VAL_W-1:0] sub_sat(
		input logic signed [VAL_W-1:0] a,
		input logic signed [VAL_W-1:0] b
	);
		logic [VAL_W:0] s;
		s = {a[VAL_W-1], a} - {b[VAL_W-1], b};
		if (s[VAL_W] != s[VAL_W-1])
			return s[VAL_W] ? SAT_MIN : SAT_MAX;
		return s[VAL_W-1:0];
	endfunction

	// exact product of magnitudes, round half away from zero, then saturate
	function automatic logic signed [VAL_W-1:0] qmul(
		input logic signed [VAL_W-1:0] a,
		input logic signed [VAL_W-1:0] b
	);
		logic             neg;
		logic [VAL_W-1:0] x;
		logic [VAL_W-1:0] y;
		logic [VAL_W-1:0] r;
		logic [127:0]     p;
		neg = a[VAL_W-1] ^ b[VAL_W-1];
		x = a[VAL_W-1] ? VAL_W'(-a) : a;
		y = b[VAL_W-1] ? VAL_W'(-b) : b;
		p = {64'd0, x} * {64'd0, y};
		p = p + (128'd1 << 31);
		if (p[127:96] != 32'd0)
			return neg ? SAT_MIN : SAT_MAX;
		r = p[95:32];
		if (!neg && r[VAL_W-1])
			return SAT_MAX;
		if (neg && r > 64'h8000_0000_0000_0000)
			return SAT_MIN;
		return neg ? VAL_W'(-r) : r;
	endfunction

	// queue every value the point will produce, in output order
	task automatic eval_laguerre(input logic [PT_W-1:0] z);
		int mc;
		int nc;
		int total;
		int cnt;
		logic signed [VAL_W-1:0] mm1;
		logic signed [VAL_W-1:0] v;
		logic signed [VAL_W-1:0] ta;
		logic signed [VAL_W-1:0] tb;
		lag_value_t res;
		mc = (m_cfg > M_MAX_DEF) ? M_MAX_DEF : int'(m_cfg);
		nc = (n_cfg > N_MAX_DEF) ? N_MAX_DEF : int'(n_cfg);
		total = mc * nc;
		cnt = 0;
		z_held = {{(VAL_W-PT_W){z[PT_W-1]}}, z};
		for (int m = 0; m < mc; m++) begin
			mm1 = longint'(m - 1) <<< 32;
			for (int n = 0; n < nc; n++) begin
				if (n == 0) begin
					v = ONE_Q;
				end else if (n == 1) begin
					v = sub_sat(longint'(m + 1) <<< 32, z_held);
				end else begin
					ta = add_sat(TWO_Q, qmul(sub_sat(mm1, z_held), INV_DEG[n]));
					tb = add_sat(ONE_Q, qmul(mm1, INV_DEG[n]));
					v = sub_sat(qmul(ta, l_prev1), qmul(tb, l_prev2));
				end
				l_prev2 = l_prev1;
				l_prev1 = v;
				cnt++;
				res.m = m[IDX_W-1:0];
				res.n = n[IDX_W-1:0];
				res.v = v;
				res.lst = (cnt == total);
				pending_vals.push_back(res);
			end
		end
	endtask

	always @(posedge clk) begin : value_check
		lag_value_t want;
		if (arst_n && valid) begin
			if (pending_vals.size() == 0) begin
				report($sformatf("value m=%0d n=%0d with nothing expected", order_m, order_n));
			end else begin
				want = pending_vals.pop_front();
				if (order_m !== want.m)
					report($sformatf("order_m got %0d want %0d", order_m, want.m));
				if (order_n !== want.n)
					report($sformatf("order_n got %0d want %0d", order_n, want.n));
				if (value !== want.v)
					report($sformatf("value m=%0d n=%0d got %h want %h",
						want.m, want.n, value, want.v));
				if (last !== want.lst)
					report($sformatf("last m=%0d n=%0d got %b want %b",
						want.m, want.n, last, want.lst));
			end
		end
	end

	function automatic logic [PT_W-1:0] rand_point();
		logic [PT_W-1:0] z;
		case ($urandom_range(0, 9))
			6, 7: z = ({7'd0, 32'($urandom_range(0, 15))} << 32) + 39'($urandom)
				- (39'd8 << 32);
			8: z = 39'(longint'($urandom_range(0, 255)) - 128) << 31;
			9: begin
				case ($urandom_range(0, 4))
					0: z = '0;
					1: z = 39'h3F_FFFF_FFFF;
					2: z = 39'h40_0000_0000;
					3: z = 39'd1;
					default: z = '1;
				endcase
			end
			default: z = PT_W'({$urandom, $urandom});
		endcase
		return z;
	endfunction

	task automatic apb_xfer(input reg_addr_e addr, input logic wr, input logic [31:0] wdata,
		output logic [31:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_counts(input logic [CNT_W-1:0] mc, input logic [CNT_W-1:0] nc);
		logic [31:0] rd;
		apb_xfer(ADDR_M_COUNT, 1'b1, {28'($urandom), mc}, rd);
		m_cfg = mc;
		apb_xfer(ADDR_N_COUNT, 1'b1, {28'($urandom), nc}, rd);
		n_cfg = nc;
		apb_xfer(ADDR_M_COUNT, 1'b0, 32'd0, rd);
		if (rd !== {28'd0, m_cfg})
			report($sformatf("m_count read %h want %h", rd, m_cfg));
		apb_xfer(ADDR_N_COUNT, 1'b0, 32'd0, rd);
		if (rd !== {28'd0, n_cfg})
			report($sformatf("n_count read %h want %h", rd, n_cfg));
	endtask

	// stop sending and let every outstanding value drain
	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		while (pending_vals.size() != 0)
			@(posedge clk);
		do @(posedge clk); while (busy);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic hold_off(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			start <= 1'b0;
			point <= rand_point();
		end
	endtask

	task automatic send_point(input logic [PT_W-1:0] z, input logic typed,
		input logic [VAL_W-1:0] want);
		lag_value_t res;
		@(negedge clk);
		start <= 1'b1;
		point <= z;
		do @(posedge clk); while (busy);
		if (typed) begin
			res.m = '0;
			res.n = '0;
			res.v = want;
			res.lst = 1'b1;
			pending_vals.push_back(res);
		end else begin
			eval_laguerre(z);
		end
	endtask

	function automatic logic [CNT_W-1:0] extreme_count();
		case ($urandom_range(0, 3))
			0: return 4'd0;
			1: return 4'd8;
			2: return 4'd15;
			default: return 4'($urandom_range(1, 15));
		endcase
	endfunction

	initial begin
		int sent;
		int phase_len;
		int eff;
		bit quiet;
		logic [CNT_W-1:0] mc;
		logic [CNT_W-1:0] nc;
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		point = '0;
		errs = 0;
		cycle_cnt = 0;
		m_cfg = M_COUNT_RST;
		n_cfg = N_COUNT_RST;
		z_held = '0;
		l_prev1 = '0;
		l_prev2 = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// first rows run on the reset counts
		foreach (DIR_ROWS[i]) begin
			if (DIR_ROWS[i].m_cnt != m_cfg || DIR_ROWS[i].n_cnt != n_cfg) begin
				wait_idle();
				set_counts(DIR_ROWS[i].m_cnt, DIR_ROWS[i].n_cnt);
			end
			send_point(DIR_ROWS[i].z, DIR_ROWS[i].typed, DIR_ROWS[i].want);
			hold_off($urandom_range(0, 4));
		end

		sent = 0;
		while (sent < ITEMS) begin
			wait_idle();
			if ($urandom_range(0, 9) == 0) begin
				mc = extreme_count();
				nc = extreme_count();
			end else begin
				mc = 4'($urandom_range(1, 4));
				nc = 4'($urandom_range(1, 5));
			end
			set_counts(mc, nc);
			eff = ((mc > 8) ? 8 : int'(mc)) * ((nc > 8) ? 8 : int'(nc));
			// full-size settings are slow, keep those phases short
			phase_len = (eff > 16) ? $urandom_range(1, 3) : $urandom_range(8, 25);
			quiet = ($urandom_range(0, 2) == 0);
			for (int k = 0; k < phase_len && sent < ITEMS; k++) begin
				send_point(rand_point(), 1'b0, '0);
				if (eff != 0)
					sent++;
				if ($urandom_range(0, 19) == 0)
					wait_idle();
				else if (!quiet)
					hold_off($urandom_range(0, 4));
			end
		end

		wait_idle();
		if (errs == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
